[hdl/sfpd_pkg.sv]
// sfpd_pkg: shared types and constants for the stuffed frame pixel decoder
// no dependencies

package sfpd_pkg;

    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] START_BYTE  = 8'h02;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h1B;
    localparam logic [BYTE_W-1:0] STOP_BYTE   = 8'h04;
    localparam logic [BYTE_W-1:0] XOR_BYTE    = 8'h20;

    // reset values of the configuration registers
    localparam logic [BYTE_W-1:0] TOPIC_LIMIT_RST  = 8'd2;
    localparam logic [BYTE_W-1:0] PIXEL_FIRST_RST  = 8'd0;
    localparam logic [BYTE_W-1:0] PIXEL_SECOND_RST = 8'd1;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOPIC_LIMIT  = 2'd0,
        CFG_PIXEL_FIRST  = 2'd1,
        CFG_PIXEL_SECOND = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_HUNT      = 3'd0,
        PH_TOPIC     = 3'd1,
        PH_ESC_TOPIC = 3'd2,
        PH_DATA      = 3'd3,
        PH_ESC_DATA  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] topic_limit;
        logic [BYTE_W-1:0] pixel_topic_first;
        logic [BYTE_W-1:0] pixel_topic_second;
    } cfg_t;

    // packet_topic sits in the lowest bits, blue in the highest
    typedef struct packed {
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] packet_topic;
    } packet_t;

endpackage

[hdl/sfpd_cfg_regs.sv]
// sfpd_cfg_regs: configuration register file, write only
// depends on sfpd_pkg

module sfpd_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [sfpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfpd_pkg::BYTE_W-1:0]        cfg_wdata,
    output sfpd_pkg::cfg_t                     cfg
);

    sfpd_pkg::cfg_t cfg_reg;
    sfpd_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (sfpd_pkg::cfg_idx_t'(cfg_index))
                sfpd_pkg::CFG_TOPIC_LIMIT:  cfg_next.topic_limit        = cfg_wdata;
                sfpd_pkg::CFG_PIXEL_FIRST:  cfg_next.pixel_topic_first  = cfg_wdata;
                sfpd_pkg::CFG_PIXEL_SECOND: cfg_next.pixel_topic_second = cfg_wdata;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.topic_limit        <= sfpd_pkg::TOPIC_LIMIT_RST;
            cfg_reg.pixel_topic_first  <= sfpd_pkg::PIXEL_FIRST_RST;
            cfg_reg.pixel_topic_second <= sfpd_pkg::PIXEL_SECOND_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/sfpd_core.sv]
// sfpd_core: deframing state machine with held topic and colour bytes
// depends on sfpd_pkg

module sfpd_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [sfpd_pkg::BYTE_W-1:0]  rx_byte,
    input  sfpd_pkg::cfg_t               cfg,
    output logic                         emit,
    output sfpd_pkg::packet_t            packet
);

    sfpd_pkg::phase_t            phase_reg, phase_next;
    logic [1:0]                  data_index_reg, data_index_next;
    logic [sfpd_pkg::BYTE_W-1:0] held_topic_reg, held_topic_next;
    logic [sfpd_pkg::BYTE_W-1:0] held_red_reg, held_red_next;
    logic [sfpd_pkg::BYTE_W-1:0] held_green_reg, held_green_next;
    logic [sfpd_pkg::BYTE_W-1:0] held_blue_reg, held_blue_next;

    logic [sfpd_pkg::BYTE_W-1:0] unesc_byte;
    logic [sfpd_pkg::BYTE_W-1:0] data_byte;
    logic                        take;
    logic                        is_pixel;

    assign unesc_byte = rx_byte ^ sfpd_pkg::XOR_BYTE;
    assign is_pixel   = (held_topic_reg == cfg.pixel_topic_first) ||
                        (held_topic_reg == cfg.pixel_topic_second);

    always_comb begin
        phase_next      = phase_reg;
        data_index_next = data_index_reg;
        held_topic_next = held_topic_reg;
        held_red_next   = held_red_reg;
        held_green_next = held_green_reg;
        held_blue_next  = held_blue_reg;
        emit            = 1'b0;
        take            = 1'b0;
        data_byte       = rx_byte;

        unique case (phase_reg)
            sfpd_pkg::PH_TOPIC: begin
                if (rx_byte == sfpd_pkg::ESCAPE_BYTE) begin
                    phase_next = sfpd_pkg::PH_ESC_TOPIC;
                end else if (rx_byte < cfg.topic_limit) begin
                    held_topic_next = rx_byte;
                    data_index_next = 2'd0;
                    phase_next      = sfpd_pkg::PH_DATA;
                end else begin
                    phase_next = sfpd_pkg::PH_HUNT;
                end
            end
            sfpd_pkg::PH_ESC_TOPIC: begin
                // topic is kept even when rejected
                held_topic_next = unesc_byte;
                if (unesc_byte < cfg.topic_limit) begin
                    data_index_next = 2'd0;
                    phase_next      = sfpd_pkg::PH_DATA;
                end else begin
                    phase_next = sfpd_pkg::PH_HUNT;
                end
            end
            sfpd_pkg::PH_DATA: begin
                if (rx_byte == sfpd_pkg::START_BYTE) begin
                    phase_next = sfpd_pkg::PH_HUNT;
                end else if (rx_byte == sfpd_pkg::STOP_BYTE) begin
                    phase_next = sfpd_pkg::PH_HUNT;
                    emit       = 1'b1;
                end else if (rx_byte == sfpd_pkg::ESCAPE_BYTE) begin
                    phase_next = sfpd_pkg::PH_ESC_DATA;
                end else begin
                    take = 1'b1;
                end
            end
            sfpd_pkg::PH_ESC_DATA: begin
                data_byte  = unesc_byte;
                take       = 1'b1;
                phase_next = sfpd_pkg::PH_DATA;
            end
            default: begin
                phase_next = (rx_byte == sfpd_pkg::START_BYTE) ? sfpd_pkg::PH_TOPIC
                                                               : sfpd_pkg::PH_HUNT;
            end
        endcase

        if (take) begin
            if (is_pixel) begin
                case (data_index_reg)
                    2'd0:    held_red_next   = data_byte;
                    2'd1:    held_green_next = data_byte;
                    2'd2:    held_blue_next  = data_byte;
                    default: ;
                endcase
            end
            // counter saturates at three
            if (data_index_reg != 2'd3) begin
                data_index_next = data_index_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= sfpd_pkg::PH_HUNT;
            data_index_reg <= 2'd0;
            held_topic_reg <= '0;
            held_red_reg   <= '0;
            held_green_reg <= '0;
            held_blue_reg  <= '0;
        end else if (step) begin
            phase_reg      <= phase_next;
            data_index_reg <= data_index_next;
            held_topic_reg <= held_topic_next;
            held_red_reg   <= held_red_next;
            held_green_reg <= held_green_next;
            held_blue_reg  <= held_blue_next;
        end
    end

    assign packet.packet_topic = held_topic_reg;
    assign packet.red          = held_red_reg;
    assign packet.green        = held_green_reg;
    assign packet.blue         = held_blue_reg;

    a_emit_only_on_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (phase_reg == sfpd_pkg::PH_DATA) && (rx_byte == sfpd_pkg::STOP_BYTE))
        else $error("packet emitted outside data phase");

    a_esc_data_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (phase_reg == sfpd_pkg::PH_ESC_DATA) |=> phase_reg == sfpd_pkg::PH_DATA)
        else $error("escaped data byte did not return to data phase");

    a_start_aborts: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (phase_reg == sfpd_pkg::PH_DATA) && (rx_byte == sfpd_pkg::START_BYTE)
        |=> phase_reg == sfpd_pkg::PH_HUNT)
        else $error("start byte did not abort the frame");

    a_index_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (data_index_reg == 2'd3) && !(step && ((phase_reg == sfpd_pkg::PH_TOPIC) ||
        (phase_reg == sfpd_pkg::PH_ESC_TOPIC))) |=> data_index_reg == 2'd3)
        else $error("saturated data index changed without a new topic");

endmodule

[hdl/stuffed_frame_pixel_decoder.sv]
// stuffed_frame_pixel_decoder: top level with input register and result register
// depends on sfpd_pkg, sfpd_cfg_regs, sfpd_core
//
// Usage:
//   s_axis_* carries one raw link byte per transfer (tdata[7:0] = rx_byte).
//   m_axis_* carries one decoded packet per stop byte that closes a frame.
//   cfg_we / cfg_index / cfg_wdata write topic_limit (0), pixel_topic_first (1)
//   and pixel_topic_second (2); other indexes are ignored. Write only while idle.
// Throughput: one byte per cycle unless a stop byte waits for the result register.
//   Every byte is taken into an input register, and the deframer state and result register update from it.
// Path: an accepted stop byte passes from the input register through the
//   deframer into the result register, which drives m_axis_tvalid and m_axis_tdata.
// Stall: the result register holds a packet until taken; bytes that cause no
//   packet keep flowing meanwhile. A stop byte waiting behind an untaken packet
//   holds the input register, and s_axis_tready drops only then.
// Reset: aresetn low for one edge or more puts the deframer in hunting,
//   clears the held topic and colours, drops both valids and loads the
//   configuration defaults (limit 2, pixel topics 0 and 1).

module stuffed_frame_pixel_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] rx_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata,   // [7:0] packet_topic,
                                                                // [15:8] red, [23:16] green,
                                                                // [31:24] blue
    input  logic                                cfg_we,
    input  logic [sfpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfpd_pkg::BYTE_W-1:0]         cfg_wdata
);

    sfpd_pkg::cfg_t              cfg;
    logic                        in_valid_reg, in_valid_next;
    logic [sfpd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        out_valid_reg, out_valid_next;
    sfpd_pkg::packet_t           out_data_reg;
    sfpd_pkg::packet_t           packet;
    logic                        emit;
    logic                        out_free;
    logic                        step;
    logic                        s_xfer;

    sfpd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sfpd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .emit    (emit),
        .packet  (packet)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    // only a packet-producing byte has to wait for the result register
    assign step          = in_valid_reg && (out_free || !emit);
    assign s_axis_tready = !in_valid_reg || step;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step && emit) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg <= s_axis_tdata;
        end
        if (step && emit) begin
            out_data_reg <= packet;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
